// File: src/srf_pkg.sv
// Shared types and constants of the signed radix formatter.
`default_nettype none

package srf_pkg;

    // Character and field widths.
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int NUM_SYMBOLS = 16;
    localparam int SYM_IDX_W   = 4;

    // Sign characters.
    localparam logic [CHAR_W-1:0] SIGN_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] SIGN_PLUS  = 8'h2B;

    // Configuration register indexes (paddr[4:3]) and reset values.
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd16;
    localparam logic [63:0]        SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [63:0]        SYMBOLS_HIGH_RESET = 64'h4645444342413938;

    // Divider: quotient bits retired per cycle and cycles per division.
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    // Digit stack: radix two gives the longest text.
    localparam int MAX_DIGITS = VALUE_W;
    localparam int DEPTH_W    = $clog2(MAX_DIGITS + 1);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NUM_SYMBOLS-1:0][CHAR_W-1:0] symbol_table_t;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } srf_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// File: src/srf_front.sv
// Front part: accepts numbers, checks the alphabet and queues sign and magnitude.
`default_nettype none

module srf_front
    import srf_pkg::*;
#(
    parameter int MAX_RADIX = 16
)
(
    input  wire logic                       start,
    input  wire logic signed [VALUE_W-1:0]  value,
    input  wire logic [RADIX_W-1:0]         radix,
    input  wire symbol_table_t              symbols,
    input  wire q_stat_t                    q_stat,
    output logic                            busy,
    output logic                            push,
    output srf_item_t                       item
);

    logic               alphabet_ok;
    logic               bad;
    logic [VALUE_W-1:0] value_u;

    // A symbol in use may not be a sign, and no two symbols in use may match.
    always_comb
    begin
        bad = (radix < 5'd2) || (radix > RADIX_W'(MAX_RADIX));
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (RADIX_W'(i) < radix)
            begin
                if ((symbols[i] == SIGN_PLUS) || (symbols[i] == SIGN_MINUS))
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < NUM_SYMBOLS; j++)
                begin
                    if ((RADIX_W'(j) < radix) && (symbols[j] == symbols[i]))
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
        alphabet_ok = !bad;
    end

    assign value_u  = value;
    assign item.neg = value_u[VALUE_W-1];
    assign item.mag = value_u[VALUE_W-1] ? (~value_u + 32'd1) : value_u;

    assign busy = q_stat.full;
    assign push = start && !q_stat.full && alphabet_ok;

endmodule

`default_nettype wire

// File: src/srf_queue.sv
// Short queue of classified numbers between front and back.
`default_nettype none

module srf_queue
    import srf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire srf_item_t item,
    input  wire logic      pop,
    output srf_item_t      head,
    output q_stat_t        q_stat
);

    srf_item_t         entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= item;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// File: src/srf_back.sv
// Back part: divides out the digits, stacks them and sends the characters.
`default_nettype none

module srf_back
    import srf_pkg::*;
#(
    parameter int MAX_RADIX = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [RADIX_W-1:0] radix,
    input  wire symbol_table_t      symbols,
    input  wire q_stat_t            q_stat,
    input  wire srf_item_t          head,
    output logic                    pop,
    output logic [CHAR_W-1:0]       character,
    output logic                    last,
    output logic                    strobe
);

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [VALUE_W-1:0]   dividend_reg;
    logic [VALUE_W-1:0]   dividend_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [DIGIT_W-1:0]   stack_reg  [MAX_DIGITS];
    logic [DIGIT_W-1:0]   stack_next [MAX_DIGITS];
    logic [CHAR_W-1:0]    character_reg;
    logic [CHAR_W-1:0]    character_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 strobe_reg;
    logic                 strobe_next;

    // Divider step: eight restoring steps, quotient bits shift in at the bottom.
    logic [VALUE_W-1:0]   dvd_step;
    logic [DIGIT_W-1:0]   rem_step;
    logic [DIGIT_W:0]     trial;
    logic                 div_done;
    logic                 quo_zero;

    always_comb
    begin
        dvd_step = dividend_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < BITS_PER_CYCLE; k++)
        begin
            trial    = {rem_step, dvd_step[VALUE_W-1]};
            dvd_step = {dvd_step[VALUE_W-2:0], 1'b0};
            if (RADIX_W'(trial) >= radix)
            begin
                rem_step    = DIGIT_W'(RADIX_W'(trial) - radix);
                dvd_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[DIGIT_W-1:0];
            end
        end
        div_done = (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));
        quo_zero = (dvd_step == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done && quo_zero)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (depth_reg == DEPTH_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        cnt_next       = cnt_reg;
        depth_next     = depth_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        stack_next     = stack_reg;
        character_next = character_reg;
        last_next      = last_reg;
        strobe_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop           = 1'b1;
                    dividend_next = head.mag;
                    neg_next      = head.neg;
                    rem_next      = '0;
                    cnt_next      = '0;
                    depth_next    = '0;
                end
            end
            ST_DIVIDE:
            begin
                dividend_next = dvd_step;
                rem_next      = rem_step;
                cnt_next      = cnt_reg + 1'b1;
                if (div_done)
                begin
                    rem_next     = '0;
                    depth_next   = depth_reg + 1'b1;
                    stack_next[0] = rem_step;
                    for (int i = 1; i < MAX_DIGITS; i++)
                    begin
                        stack_next[i] = stack_reg[i-1];
                    end
                end
            end
            ST_SIGN:
            begin
                character_next = SIGN_MINUS;
                last_next      = 1'b0;
                strobe_next    = 1'b1;
            end
            ST_EMIT:
            begin
                character_next = symbols[SYM_IDX_W'(stack_reg[0])];
                last_next      = (depth_reg == DEPTH_W'(1));
                strobe_next    = 1'b1;
                depth_next     = depth_reg - 1'b1;
                for (int i = 0; i < MAX_DIGITS - 1; i++)
                begin
                    stack_next[i] = stack_reg[i+1];
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            depth_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            depth_reg  <= depth_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        stack_reg     <= stack_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign character = character_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

endmodule

`default_nettype wire

// File: src/signed_radix_formatter.sv
// Top level of the signed radix formatter: register port, front, queue and back.
`default_nettype none

// The block turns a signed 32-bit number into its text in a radix of 2 to
// MAX_RADIX, drawn from a 16-symbol alphabet held in configuration registers.
// A number is accepted at a clock edge where start is high and busy is low; a
// two-entry queue stands between the accepting front and the converting back,
// so busy rises only when two numbers wait behind the one in conversion. Each
// character of the text appears on character for exactly one cycle with strobe
// high, most significant digit first, a minus sign before the digits of a
// negative number, and last high on the final character. The receiver cannot
// stall these transfers, so it must take every character in the cycle it is
// shown. If the alphabet is invalid (radix below two or above MAX_RADIX, a
// sign character among the symbols in use, or two equal symbols in use), the
// number is not queued and yields no characters. The back takes a number from
// the queue, divides out all its digits in the restoring divider, which
// retires eight quotient bits each cycle, and then sends the characters; it
// takes no further number from the queue until the final character is sent.
// Registers are written through the APB-style port at byte addresses 0
// (radix), 8 (symbols 0 to 7) and 16 (symbols 8 to 15); they must be written
// only while no conversion is in progress.
module signed_radix_formatter
    import srf_pkg::*;
#(
    parameter int MAX_RADIX = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           busy,
    output logic [CHAR_W-1:0]              character,
    output logic                           last,
    output logic                           strobe,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [4:0]                paddr,
    input  wire logic [63:0]               pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_next;
    logic [63:0]          symbols_low_reg;
    logic [63:0]          symbols_low_next;
    logic [63:0]          symbols_high_reg;
    logic [63:0]          symbols_high_next;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    symbol_table_t        symbols;

    q_stat_t              q_stat;
    logic                 push;
    logic                 pop;
    srf_item_t            item;
    srf_item_t            head;

    // Registers sit on 8-byte boundaries; the low address bits are not decoded.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        radix_next        = radix_reg;
        symbols_low_next  = symbols_low_reg;
        symbols_high_next = symbols_high_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_RADIX:        radix_next        = pwdata[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_next  = pwdata;
                REG_SYMBOLS_HIGH: symbols_high_next = pwdata;
                default:          radix_next        = radix_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RADIX:        prdata = {59'd0, radix_reg};
            REG_SYMBOLS_LOW:  prdata = symbols_low_reg;
            REG_SYMBOLS_HIGH: prdata = symbols_high_reg;
            default:          prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
        end
        else
        begin
            radix_reg        <= radix_next;
            symbols_low_reg  <= symbols_low_next;
            symbols_high_reg <= symbols_high_next;
        end
    end

    // Symbol 0 is the low byte of the low register.
    assign symbols = {symbols_high_reg, symbols_low_reg};

    srf_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .start   (start),
        .value   (value),
        .radix   (radix_reg),
        .symbols (symbols),
        .q_stat  (q_stat),
        .busy    (busy),
        .push    (push),
        .item    (item)
    );

    srf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    srf_back #(
        .MAX_RADIX (MAX_RADIX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix_reg),
        .symbols   (symbols),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

    // After the final character the back returns to idle, so no character
    // can follow in the next cycle.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("character transfer right after the final character");

    // The queue fills only through an accepted number.
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(push))
        else $error("busy rose without an accepted number");

    // The queue frees a slot only when the back takes a number.
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(pop))
        else $error("busy fell without the back taking a number");

endmodule

`default_nettype wire
